@@ design/rdp_pkg.sv @@
// Shared constants and types for the ridge pixel detector.
package rdp_pkg;

    localparam int PIXEL_BITS      = 16;
    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int LINE_BITS       = 2 * PIXEL_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [LINE_BITS-1:0]  t_line;

    typedef struct packed {
        logic   fire;
        t_pixel pixel;
        t_row   row;
        t_col   col;
    } t_step;

    typedef struct packed {
        logic valid;
        logic is_ridge;
        t_row row;
        t_col col;
    } t_result;

endpackage

@@ design/rdp_line_ram.sv @@
// Line buffer memory holding the upper and middle rows, one column per entry.
module rdp_line_ram (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  rdp_pkg::t_col        i_waddr,
    input  rdp_pkg::t_line       i_wdata,
    input  logic                 i_re,
    input  rdp_pkg::t_col        i_raddr,
    output rdp_pkg::t_line       o_rdata
);

    rdp_pkg::t_line r_mem [rdp_pkg::MAX_WIDTH];
    rdp_pkg::t_line r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rdp_decide.sv @@
// Window registers and the ridge decision for the pixel one row up and one column left.
module rdp_decide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdp_pkg::t_step       i_step,
    input  rdp_pkg::t_pixel      i_up_c,
    input  rdp_pkg::t_pixel      i_mid_c,
    input  rdp_pkg::t_pixel      i_min_value,
    output rdp_pkg::t_result     o_result
);

    rdp_pkg::t_pixel r_up1;
    rdp_pkg::t_pixel r_mid1;
    rdp_pkg::t_pixel r_mid2;
    rdp_pkg::t_pixel r_low1;
    logic            vert_ok;
    logic            horz_ok;
    logic            interior;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up1  <= '0;
            r_mid1 <= '0;
            r_mid2 <= '0;
            r_low1 <= '0;
        end else if (i_step.fire) begin
            r_up1  <= i_up_c;
            r_mid2 <= r_mid1;
            r_mid1 <= i_mid_c;
            r_low1 <= i_step.pixel;
        end
    end

    always_comb begin
        vert_ok  = (r_mid1 >= r_up1) && (r_mid1 > r_low1);
        horz_ok  = (r_mid1 >= r_mid2) && (r_mid1 > i_mid_c);
        interior = (i_step.row >= rdp_pkg::ROW_BITS'(2)) &&
                   (i_step.col >= rdp_pkg::COL_BITS'(2));
        o_result.valid    = (i_step.row != '0) && (i_step.col != '0);
        o_result.is_ridge = interior && (r_mid1 > i_min_value) && (vert_ok || horz_ok);
        o_result.row      = i_step.row - rdp_pkg::ROW_BITS'(1);
        o_result.col      = i_step.col - rdp_pkg::COL_BITS'(1);
    end

endmodule

@@ design/ridge_pixel_detector_top.sv @@
// Top level of the ridge pixel detector: handshakes, configuration and frame counters.
//
// The detector takes one pixel per clock in raster order and gives, for each pixel
// at row r and column c with r and c both nonzero, one result beat for the pixel at
// (r-1, c-1); pixels in the first row or first column give no beat. From input
// beat to output beat a pixel passes the line buffer read and the input register,
// then the decision and the output register. The sustained rate is one pixel per
// cycle, since the line buffer has a separate read port and write port and each
// pixel uses one of each; the input stalls only while a stalled output beat is
// waiting and the input register is full. Writing the image width or height
// restarts the frame at row 0, column 0. Write configuration only while no pixel
// is in flight.
module ridge_pixel_detector_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [rdp_pkg::PIXEL_BITS-1:0]         i_pixel,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rdp_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [rdp_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_is_ridge,
    output logic [rdp_pkg::ROW_BITS-1:0]           o_out_row,
    output logic [rdp_pkg::COL_BITS-1:0]           o_out_column
);

    rdp_pkg::t_pixel r_min_value;
    rdp_pkg::t_col   r_last_col;
    rdp_pkg::t_row   r_last_row;
    rdp_pkg::t_col   r_col;
    rdp_pkg::t_row   r_row;

    logic            r_s1_valid;
    rdp_pkg::t_pixel r_s1_pixel;
    rdp_pkg::t_col   r_s1_col;
    rdp_pkg::t_row   r_s1_row;

    logic            r_out_valid;
    logic            r_out_ridge;
    rdp_pkg::t_row   r_out_row;
    rdp_pkg::t_col   r_out_col;

    logic                  out_free;
    logic                  s1_fire;
    logic                  in_accept;
    logic                  cfg_write;
    rdp_pkg::t_line        rd_data;
    rdp_pkg::t_step        step;
    rdp_pkg::t_result      result;
    logic [rdp_pkg::WIDTH_REG_BITS-1:0]  width_raw;
    logic [rdp_pkg::WIDTH_REG_BITS-1:0]  width_clamp;
    logic [rdp_pkg::HEIGHT_REG_BITS-1:0] height_raw;
    logic [rdp_pkg::HEIGHT_REG_BITS-1:0] height_clamp;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        width_raw  = i_cfg_data[rdp_pkg::WIDTH_REG_BITS-1:0];
        height_raw = i_cfg_data[rdp_pkg::HEIGHT_REG_BITS-1:0];
        if (width_raw < rdp_pkg::WIDTH_REG_BITS'(3)) begin
            width_clamp = rdp_pkg::WIDTH_REG_BITS'(3);
        end else if (width_raw > rdp_pkg::WIDTH_REG_BITS'(rdp_pkg::MAX_WIDTH)) begin
            width_clamp = rdp_pkg::WIDTH_REG_BITS'(rdp_pkg::MAX_WIDTH);
        end else begin
            width_clamp = width_raw;
        end
        if (height_raw < rdp_pkg::HEIGHT_REG_BITS'(3)) begin
            height_clamp = rdp_pkg::HEIGHT_REG_BITS'(3);
        end else if (height_raw > rdp_pkg::HEIGHT_REG_BITS'(rdp_pkg::MAX_HEIGHT)) begin
            height_clamp = rdp_pkg::HEIGHT_REG_BITS'(rdp_pkg::MAX_HEIGHT);
        end else begin
            height_clamp = height_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value <= '0;
            r_last_col  <= rdp_pkg::COL_BITS'(rdp_pkg::MAX_WIDTH - 1);
            r_last_row  <= rdp_pkg::ROW_BITS'(rdp_pkg::MAX_HEIGHT - 1);
            r_col       <= '0;
            r_row       <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                rdp_pkg::CFG_MIN_VALUE: begin
                    r_min_value <= i_cfg_data[rdp_pkg::PIXEL_BITS-1:0];
                end
                rdp_pkg::CFG_IMAGE_WIDTH: begin
                    r_last_col <= rdp_pkg::COL_BITS'(width_clamp - 1'b1);
                    r_col      <= '0;
                    r_row      <= '0;
                end
                rdp_pkg::CFG_IMAGE_HEIGHT: begin
                    r_last_row <= rdp_pkg::ROW_BITS'(height_clamp - 1'b1);
                    r_col      <= '0;
                    r_row      <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            if (r_col >= r_last_col) begin
                r_col <= '0;
                r_row <= (r_row >= r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
        end
    end

    rdp_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata ({rd_data[rdp_pkg::PIXEL_BITS-1:0], r_s1_pixel}),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    assign step.fire  = s1_fire;
    assign step.pixel = r_s1_pixel;
    assign step.row   = r_s1_row;
    assign step.col   = r_s1_col;

    rdp_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_up_c      (rd_data[rdp_pkg::LINE_BITS-1:rdp_pkg::PIXEL_BITS]),
        .i_mid_c     (rd_data[rdp_pkg::PIXEL_BITS-1:0]),
        .i_min_value (r_min_value),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_ridge <= result.is_ridge;
            r_out_row   <= result.row;
            r_out_col   <= result.col;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_ridge   = r_out_ridge;
    assign o_out_row    = r_out_row;
    assign o_out_column = r_out_col;

    a_border_not_ridge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_ridge |-> (o_out_row != '0) && (o_out_column != '0))
        else $error("Ridge flag set on a border pixel.");

    a_last_col_not_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_column < r_last_col)
        else $error("Result beat for the last column of a row.");

    a_last_row_not_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_row < r_last_row)
        else $error("Result beat for the last row of a frame.");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_s1_valid)
        else $error("Accepted pixel did not reach the decision stage.");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ridge pixel detector: directed frames, random frames, checks.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS   = 250;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [rdp_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic [1:0] {FLAG_PREDICTED, FLAG_ZERO, FLAG_ONE} t_flag_src;
    typedef enum logic [1:0] {CONTENT_FULL, CONTENT_LOW, CONTENT_MIXED} t_content;

    typedef struct packed {
        logic          is_ridge;
        rdp_pkg::t_row row;
        rdp_pkg::t_col col;
    } t_decision;

    typedef struct {
        rdp_pkg::t_pixel px;
        t_flag_src       flag;
    } t_table_row;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    rdp_pkg::t_pixel                    i_pixel     = '0;
    logic                               i_cfg_valid = 1'b0;
    logic [rdp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [rdp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                               i_out_stall = 1'b0;
    logic                               o_in_stall;
    logic                               o_cfg_ready;
    logic                               o_out_valid;
    logic                               o_is_ridge;
    rdp_pkg::t_row                      o_out_row;
    rdp_pkg::t_col                      o_out_column;

    ridge_pixel_detector_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel      (i_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_is_ridge   (o_is_ridge),
        .o_out_row    (o_out_row),
        .o_out_column (o_out_column)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic [rdp_pkg::CFG_DATA_BITS-1:0]   min_level  = '0;
    logic [rdp_pkg::WIDTH_REG_BITS-1:0]  width_reg  =
        rdp_pkg::WIDTH_REG_BITS'(rdp_pkg::MAX_WIDTH);
    logic [rdp_pkg::HEIGHT_REG_BITS-1:0] height_reg =
        rdp_pkg::HEIGHT_REG_BITS'(rdp_pkg::MAX_HEIGHT);
    rdp_pkg::t_pixel upper_row [rdp_pkg::MAX_WIDTH] = '{default: '0};
    rdp_pkg::t_pixel middle_row [rdp_pkg::MAX_WIDTH] = '{default: '0};
    rdp_pkg::t_pixel win_upper  = '0;
    rdp_pkg::t_pixel win_center = '0;
    rdp_pkg::t_pixel win_left   = '0;
    rdp_pkg::t_pixel win_lower  = '0;
    int              row_pos    = 0;
    int              col_pos    = 0;

    t_decision awaited_decisions[$];
    t_flag_src flag_sources[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    int        stall_mode  = 0;
    int        stall_span  = 0;

    t_table_row directed_rows [27] = '{
        '{16'd0,     FLAG_PREDICTED}, '{16'd500,   FLAG_PREDICTED}, '{16'd0,     FLAG_PREDICTED},
        '{16'd600,   FLAG_PREDICTED}, '{16'd500,   FLAG_ZERO},      '{16'd600,   FLAG_ZERO},
        '{16'd65535, FLAG_PREDICTED}, '{16'd499,   FLAG_ZERO},      '{16'd65535, FLAG_ONE},
        '{16'd65535, FLAG_PREDICTED}, '{16'd0,     FLAG_PREDICTED}, '{16'd65535, FLAG_PREDICTED},
        '{16'd65535, FLAG_PREDICTED}, '{16'd65535, FLAG_ZERO},      '{16'd65534, FLAG_ZERO},
        '{16'd0,     FLAG_PREDICTED}, '{16'd65535, FLAG_ZERO},      '{16'd0,     FLAG_ONE},
        '{16'd0,     FLAG_PREDICTED}, '{16'd0,     FLAG_PREDICTED}, '{16'd0,     FLAG_PREDICTED},
        '{16'd0,     FLAG_PREDICTED}, '{16'd100,   FLAG_ZERO},      '{16'd0,     FLAG_ZERO},
        '{16'd0,     FLAG_PREDICTED}, '{16'd0,     FLAG_ZERO},      '{16'd0,     FLAG_ZERO}
    };

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Advances the window by one pixel and queues the decision it produces, if any.
    task automatic decide_ridge(input rdp_pkg::t_pixel px, input t_flag_src flag);
        int              w;
        int              h;
        rdp_pkg::t_pixel up_c;
        rdp_pkg::t_pixel mid_c;
        t_decision       d;
        w = (width_reg < 3) ? 3 : (width_reg > rdp_pkg::MAX_WIDTH) ? rdp_pkg::MAX_WIDTH :
            int'(width_reg);
        h = (height_reg < 3) ? 3 : (height_reg > rdp_pkg::MAX_HEIGHT) ? rdp_pkg::MAX_HEIGHT :
            int'(height_reg);
        up_c  = upper_row[col_pos];
        mid_c = middle_row[col_pos];
        if (row_pos >= 1 && col_pos >= 1) begin
            d.is_ridge = row_pos >= 2 && col_pos >= 2 && win_center > min_level &&
                         ((win_center >= win_upper && win_center > win_lower) ||
                          (win_center >= win_left && win_center > mid_c));
            if (flag != FLAG_PREDICTED) begin
                d.is_ridge = (flag == FLAG_ONE);
            end
            d.row = rdp_pkg::t_row'(row_pos - 1);
            d.col = rdp_pkg::t_col'(col_pos - 1);
            awaited_decisions = {awaited_decisions, d};
        end
        win_upper  = up_c;
        win_left   = win_center;
        win_center = mid_c;
        win_lower  = px;
        upper_row[col_pos]  = mid_c;
        middle_row[col_pos] = px;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_decision want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_decisions.size() == 0) begin
                    report_mismatch($sformatf("beat at row %0d column %0d with nothing expected",
                                              o_out_row, o_out_column));
                end else begin
                    want = awaited_decisions.pop_front();
                    if (o_is_ridge !== want.is_ridge) begin
                        report_mismatch($sformatf("is_ridge %b, expected %b at row %0d column %0d",
                                                  o_is_ridge, want.is_ridge, want.row, want.col));
                    end
                    if (o_out_row !== want.row) begin
                        report_mismatch($sformatf("out_row %0d, expected %0d",
                                                  o_out_row, want.row));
                    end
                    if (o_out_column !== want.col) begin
                        report_mismatch($sformatf("out_column %0d, expected %0d",
                                                  o_out_column, want.col));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rdp_pkg::CFG_MIN_VALUE: begin
                        min_level = i_cfg_data;
                    end
                    rdp_pkg::CFG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[rdp_pkg::WIDTH_REG_BITS-1:0];
                        row_pos = 0;
                        col_pos = 0;
                    end
                    rdp_pkg::CFG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[rdp_pkg::HEIGHT_REG_BITS-1:0];
                        row_pos = 0;
                        col_pos = 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                decide_ridge(i_pixel, flag_sources.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(1, 60);
            end else begin
                stall_span = stall_span - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= (stall_span % 8) < 5;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_register(input logic [rdp_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [rdp_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The sender holds the beat until it is taken, then may drop valid for a gap.
    task automatic send_pixel(input rdp_pkg::t_pixel px, input t_flag_src flag);
        int gap;
        flag_sources = {flag_sources, flag};
        i_pixel    <= px;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_decisions.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic stream_pixels(input int count, input t_content content, input int pause_at);
        rdp_pkg::t_pixel px;
        t_content        pick;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) begin
                drain();
            end
            pick = (content == CONTENT_MIXED) ? t_content'($urandom_range(0, 2)) : content;
            case (pick)
                CONTENT_FULL: px = rdp_pkg::t_pixel'($urandom);
                CONTENT_LOW:  px = rdp_pkg::t_pixel'($urandom_range(0, 7));
                default:      px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            send_pixel(px, FLAG_PREDICTED);
        end
    endtask

    initial begin
        int random_sent;
        int count;
        int writes;
        int dim;
        logic [rdp_pkg::CFG_INDEX_BITS-1:0] idx;
        logic [rdp_pkg::CFG_DATA_BITS-1:0]  data;
        random_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register values after reset: a full row plus part of the next.
        stream_pixels(rdp_pkg::MAX_WIDTH + 4, CONTENT_FULL, -1);
        drain();

        write_register(rdp_pkg::CFG_MIN_VALUE, 16'd100);
        write_register(rdp_pkg::CFG_IMAGE_WIDTH, 16'd3);
        write_register(rdp_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        write_register(CFG_UNUSED_INDEX, 16'hFFFF);
        foreach (directed_rows[k]) begin
            send_pixel(directed_rows[k].px, directed_rows[k].flag);
        end
        drain();

        while (random_sent < RANDOM_ITEMS) begin
            writes = $urandom_range(0, 4);
            for (int n = 0; n < writes; n++) begin
                idx = rdp_pkg::CFG_INDEX_BITS'($urandom_range(0, 3));
                dim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                case (idx)
                    rdp_pkg::CFG_MIN_VALUE: begin
                        case ($urandom_range(0, 3))
                            0: data = 16'h0000;
                            1: data = 16'hFFFF;
                            2: data = rdp_pkg::CFG_DATA_BITS'($urandom_range(0, 6));
                            default: data = rdp_pkg::CFG_DATA_BITS'($urandom);
                        endcase
                    end
                    rdp_pkg::CFG_IMAGE_WIDTH: data = {5'($urandom), 11'(dim)};
                    rdp_pkg::CFG_IMAGE_HEIGHT: data = {3'($urandom), 13'(dim)};
                    default: data = rdp_pkg::CFG_DATA_BITS'($urandom);
                endcase
                write_register(idx, data);
            end
            count = $urandom_range(10, 150);
            stream_pixels(count, t_content'($urandom_range(0, 2)),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, count - 1) : -1);
            random_sent += count;
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && awaited_decisions.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/rdp_pkg.sv
design/rdp_line_ram.sv
design/rdp_decide.sv
design/ridge_pixel_detector_top.sv
tb/testbench.sv
